// ===== hdl/ogsc_pkg.sv =====
`default_nettype none

package ogsc_pkg;

    // Field and register widths fixed by the interface.
    localparam int THRESH_W    = 16;
    localparam int DUTY_W      = 8;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int TIMER_BITS_DEF = 16;

    // Controller states.
    typedef enum logic [2:0] {
        MODE_FWD     = 3'd0,
        MODE_BLOCKED = 3'd1,
        MODE_LEFT    = 3'd2,
        MODE_RIGHT   = 3'd3,
        MODE_CONFIRM = 3'd4
    } mode_t;

    // Motor commands.
    typedef enum logic [1:0] {
        CMD_STOP  = 2'd0,
        CMD_FWD   = 2'd1,
        CMD_LEFT  = 2'd2,
        CMD_RIGHT = 2'd3
    } cmd_t;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_PAUSE_TICKS   = 2'd0;
    localparam logic [1:0] REG_CONFIRM_TICKS = 2'd1;
    localparam logic [1:0] REG_FORWARD_DUTY  = 2'd2;
    localparam logic [1:0] REG_SIDE_DUTY     = 2'd3;

    // Reset values of the registers.
    localparam logic [THRESH_W-1:0] PAUSE_TICKS_RST   = 16'd500;
    localparam logic [THRESH_W-1:0] CONFIRM_TICKS_RST = 16'd300;
    localparam logic [DUTY_W-1:0]   FORWARD_DUTY_RST  = 8'd200;
    localparam logic [DUTY_W-1:0]   SIDE_DUTY_RST     = 8'd150;

    // Sensor flags of one request, ahead_blocked in the lowest bit.
    typedef struct packed {
        logic right_hit;
        logic left_hit;
        logic front_clear;
        logic ahead_blocked;
    } sensor_t;

    // Configuration seen by the step logic.
    typedef struct packed {
        logic [THRESH_W-1:0] pause_ticks;
        logic [THRESH_W-1:0] confirm_ticks;
        logic [DUTY_W-1:0]   forward_duty;
        logic [DUTY_W-1:0]   side_duty;
    } cfg_t;

    // Controller state apart from the dwell counter.
    typedef struct packed {
        mode_t mode;
        logic  prefer_left;
    } ctrl_t;

    // One result, mode_now in the lowest bits.
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        cmd_t              motor_cmd;
        mode_t             mode_now;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/obstacle_gap_search_controller_unit.sv =====
// Obstacle gap-search controller. Each request on the s_ channel is one
// millisecond tick with four sensor flags; each produces exactly one result
// on the m_ channel holding the new controller state, the motor command and
// its PWM duty. The state update is a single pass of flat logic, so a
// request is taken every clock cycle; the only limit on rate is the result
// side, where an output register and a one-entry skid register hold up to
// two results, and s_tready falls only when both are full. Thresholds and
// duties are set through the APB port; the user must do so only while the
// block is idle, which is not enforced. The dwell counter, TIMER_BITS wide,
// holds at its maximum: a threshold at or above it makes the wait endless.

`default_nettype none

module obstacle_gap_search_controller_unit #(
    parameter int TIMER_BITS = ogsc_pkg::TIMER_BITS_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    // Request channel.
    input  wire                                s_tvalid,
    output logic                               s_tready,
    // [0] ahead_blocked, [1] front_clear, [2] left_hit, [3] right_hit
    input  wire [ogsc_pkg::S_TDATA_W-1:0]      s_tdata,
    // Result channel.
    output logic                               m_tvalid,
    input  wire                                m_tready,
    // [2:0] mode_now, [4:3] motor_cmd, [12:5] duty
    output logic [ogsc_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration port.
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [ogsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire [ogsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ogsc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                               pready
);

    ogsc_pkg::cfg_t    cfg_reg;
    ogsc_pkg::ctrl_t   ctrl_reg;
    ogsc_pkg::ctrl_t   ctrl_next;
    logic [TIMER_BITS-1:0] dwell_reg;
    logic [TIMER_BITS-1:0] dwell_next;
    ogsc_pkg::result_t step_result;
    logic [1:0]        reg_idx;
    logic              cfg_write;

    logic                            accept;
    logic                            take;
    logic                            out_valid_reg, out_valid_next;
    logic                            skid_valid_reg, skid_valid_next;
    logic [ogsc_pkg::M_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic [ogsc_pkg::M_TDATA_W-1:0]  skid_data_reg, skid_data_next;
    logic [ogsc_pkg::M_TDATA_W-1:0]  new_data;

    // Configuration registers.
    assign pready    = 1'b1;
    assign reg_idx   = paddr[3:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pause_ticks   <= ogsc_pkg::PAUSE_TICKS_RST;
            cfg_reg.confirm_ticks <= ogsc_pkg::CONFIRM_TICKS_RST;
            cfg_reg.forward_duty  <= ogsc_pkg::FORWARD_DUTY_RST;
            cfg_reg.side_duty     <= ogsc_pkg::SIDE_DUTY_RST;
        end else if (cfg_write) begin
            unique case (reg_idx)
                ogsc_pkg::REG_PAUSE_TICKS:
                    cfg_reg.pause_ticks   <= pwdata[ogsc_pkg::THRESH_W-1:0];
                ogsc_pkg::REG_CONFIRM_TICKS:
                    cfg_reg.confirm_ticks <= pwdata[ogsc_pkg::THRESH_W-1:0];
                ogsc_pkg::REG_FORWARD_DUTY:
                    cfg_reg.forward_duty  <= pwdata[ogsc_pkg::DUTY_W-1:0];
                ogsc_pkg::REG_SIDE_DUTY:
                    cfg_reg.side_duty     <= pwdata[ogsc_pkg::DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (reg_idx)
            ogsc_pkg::REG_PAUSE_TICKS:
                prdata = ogsc_pkg::APB_DATA_W'(cfg_reg.pause_ticks);
            ogsc_pkg::REG_CONFIRM_TICKS:
                prdata = ogsc_pkg::APB_DATA_W'(cfg_reg.confirm_ticks);
            ogsc_pkg::REG_FORWARD_DUTY:
                prdata = ogsc_pkg::APB_DATA_W'(cfg_reg.forward_duty);
            ogsc_pkg::REG_SIDE_DUTY:
                prdata = ogsc_pkg::APB_DATA_W'(cfg_reg.side_duty);
            default:
                prdata = '0;
        endcase
    end

    // One controller step per accepted request.
    ogsc_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .ctrl_cur   (ctrl_reg),
        .dwell_cur  (dwell_reg),
        .sensor     (ogsc_pkg::sensor_t'(s_tdata[3:0])),
        .cfg        (cfg_reg),
        .ctrl_next  (ctrl_next),
        .dwell_next (dwell_next),
        .result     (step_result)
    );

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;
    assign new_data = ogsc_pkg::M_TDATA_W'(step_result);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.mode        <= ogsc_pkg::MODE_FWD;
            ctrl_reg.prefer_left <= 1'b1;
            dwell_reg            <= '0;
        end else if (accept) begin
            ctrl_reg  <= ctrl_next;
            dwell_reg <= dwell_next;
        end
    end

    // Output register with a one-entry skid register behind it.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (take) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end else if (accept) begin
                out_data_next = new_data;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (accept) begin
            if (out_valid_reg) begin
                skid_valid_next = 1'b1;
                skid_data_next  = new_data;
            end else begin
                out_valid_next = 1'b1;
                out_data_next  = new_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/ogsc_step.sv =====
`default_nettype none

module ogsc_step #(
    parameter int TIMER_BITS = ogsc_pkg::TIMER_BITS_DEF
) (
    input  wire ogsc_pkg::ctrl_t   ctrl_cur,
    input  wire [TIMER_BITS-1:0]   dwell_cur,
    input  wire ogsc_pkg::sensor_t sensor,
    input  wire ogsc_pkg::cfg_t    cfg,
    output ogsc_pkg::ctrl_t        ctrl_next,
    output logic [TIMER_BITS-1:0]  dwell_next,
    output ogsc_pkg::result_t      result
);

    localparam int CMP_W = (TIMER_BITS > ogsc_pkg::THRESH_W) ? TIMER_BITS
                                                              : ogsc_pkg::THRESH_W;

    logic [TIMER_BITS-1:0] elapsed;
    logic                  pause_done;
    logic                  confirm_done;
    ogsc_pkg::mode_t       side_mode;

    // Elapsed ticks including this one, held at the counter's maximum.
    assign elapsed = (&dwell_cur) ? dwell_cur : dwell_cur + TIMER_BITS'(1);

    assign pause_done   = CMP_W'(elapsed) > CMP_W'(cfg.pause_ticks);
    assign confirm_done = CMP_W'(elapsed) > CMP_W'(cfg.confirm_ticks);
    assign side_mode    = ctrl_cur.prefer_left ? ogsc_pkg::MODE_LEFT
                                               : ogsc_pkg::MODE_RIGHT;

    // Next state and side preference.
    always_comb begin
        ctrl_next = ctrl_cur;
        unique case (ctrl_cur.mode)
            ogsc_pkg::MODE_BLOCKED: begin
                if (pause_done) begin
                    ctrl_next.mode = side_mode;
                end
            end
            ogsc_pkg::MODE_LEFT: begin
                if (sensor.left_hit) begin
                    ctrl_next.prefer_left = 1'b0;
                    ctrl_next.mode        = ogsc_pkg::MODE_RIGHT;
                end else if (sensor.front_clear) begin
                    ctrl_next.mode = ogsc_pkg::MODE_CONFIRM;
                end
            end
            ogsc_pkg::MODE_RIGHT: begin
                if (sensor.right_hit) begin
                    ctrl_next.prefer_left = 1'b1;
                    ctrl_next.mode        = ogsc_pkg::MODE_LEFT;
                end else if (sensor.front_clear) begin
                    ctrl_next.mode = ogsc_pkg::MODE_CONFIRM;
                end
            end
            ogsc_pkg::MODE_CONFIRM: begin
                if (sensor.ahead_blocked) begin
                    ctrl_next.mode = side_mode;
                end else if (sensor.front_clear && confirm_done) begin
                    ctrl_next.mode = ogsc_pkg::MODE_FWD;
                end
            end
            default: begin
                // Forward, and any code outside the state list.
                ctrl_next.mode = sensor.ahead_blocked ? ogsc_pkg::MODE_BLOCKED
                                                      : ogsc_pkg::MODE_FWD;
            end
        endcase
    end

    // Every state change, a side flip included, restarts the dwell count.
    assign dwell_next = (ctrl_next.mode != ctrl_cur.mode) ? '0 : elapsed;

    // Motor command for the new state.
    always_comb begin
        result.mode_now = ctrl_next.mode;
        case (ctrl_next.mode)
            ogsc_pkg::MODE_FWD: begin
                result.motor_cmd = ogsc_pkg::CMD_FWD;
                result.duty      = cfg.forward_duty;
            end
            ogsc_pkg::MODE_LEFT: begin
                result.motor_cmd = ogsc_pkg::CMD_LEFT;
                result.duty      = cfg.side_duty;
            end
            ogsc_pkg::MODE_RIGHT: begin
                result.motor_cmd = ogsc_pkg::CMD_RIGHT;
                result.duty      = cfg.side_duty;
            end
            ogsc_pkg::MODE_CONFIRM: begin
                result.motor_cmd = ctrl_next.prefer_left ? ogsc_pkg::CMD_LEFT
                                                         : ogsc_pkg::CMD_RIGHT;
                result.duty      = cfg.side_duty;
            end
            default: begin
                result.motor_cmd = ogsc_pkg::CMD_STOP;
                result.duty      = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/ogsc_checker.sv =====
`default_nettype none

module ogsc_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_tready,
    input wire                                m_tvalid,
    input wire                                m_tready,
    input wire [ogsc_pkg::M_TDATA_W-1:0]      m_tdata
);

    // No result is pending straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Requests are refused only while results are waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("request refused with no result pending");

    // A stalled result holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // While blocked the motor stands still with zero duty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] == ogsc_pkg::MODE_BLOCKED)
        |-> (m_tdata[4:3] == ogsc_pkg::CMD_STOP) && (m_tdata[12:5] == '0))
        else $error("motor running in blocked state");

endmodule

bind obstacle_gap_search_controller_unit ogsc_checker u_ogsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== test/ogsc_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, result and configuration channels of the gap-search
// controller, predicts the command for every accepted request and compares
// each accepted result with the oldest prediction still outstanding.
module ogsc_scoreboard #(
    parameter int TIMER_BITS = ogsc_pkg::TIMER_BITS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    input  wire                             s_tvalid,
    input  wire                             s_tready,
    input  wire [ogsc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire                             m_tvalid,
    input  wire                             m_tready,
    input  wire [ogsc_pkg::M_TDATA_W-1:0]   m_tdata,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire [ogsc_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire [ogsc_pkg::APB_DATA_W-1:0]  pwdata,
    input  wire [ogsc_pkg::APB_DATA_W-1:0]  prdata,
    input  wire                             pready,
    output int unsigned                     fail_count,
    output int unsigned                     pending_count
);

    // Local copy of the register file.
    logic [ogsc_pkg::THRESH_W-1:0] pause_ticks;
    logic [ogsc_pkg::THRESH_W-1:0] confirm_ticks;
    logic [ogsc_pkg::DUTY_W-1:0]   forward_duty;
    logic [ogsc_pkg::DUTY_W-1:0]   side_duty;

    // Local copy of the controller state.
    ogsc_pkg::mode_t       mode;
    logic                  prefer_left;
    logic [TIMER_BITS-1:0] dwell;

    // Commands predicted but not yet seen on the result channel.
    ogsc_pkg::result_t     pending_commands [$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    // Advances the controller by one tick and returns the command it issues.
    function automatic ogsc_pkg::result_t advance_controller(
        input ogsc_pkg::sensor_t flags);
        logic [TIMER_BITS-1:0] elapsed;
        ogsc_pkg::mode_t       nxt;
        ogsc_pkg::result_t     res;
        elapsed = (dwell == {TIMER_BITS{1'b1}}) ? dwell : dwell + 1'b1;
        nxt = mode;
        case (mode)
            ogsc_pkg::MODE_BLOCKED: begin
                if (elapsed > pause_ticks)
                    nxt = prefer_left ? ogsc_pkg::MODE_LEFT : ogsc_pkg::MODE_RIGHT;
            end
            ogsc_pkg::MODE_LEFT: begin
                // A wall hit flips the preferred side and wins over a clear front.
                if (flags.left_hit) begin
                    prefer_left = 1'b0;
                    nxt = ogsc_pkg::MODE_RIGHT;
                end else if (flags.front_clear) begin
                    nxt = ogsc_pkg::MODE_CONFIRM;
                end
            end
            ogsc_pkg::MODE_RIGHT: begin
                if (flags.right_hit) begin
                    prefer_left = 1'b1;
                    nxt = ogsc_pkg::MODE_LEFT;
                end else if (flags.front_clear) begin
                    nxt = ogsc_pkg::MODE_CONFIRM;
                end
            end
            ogsc_pkg::MODE_CONFIRM: begin
                if (flags.ahead_blocked)
                    nxt = prefer_left ? ogsc_pkg::MODE_LEFT : ogsc_pkg::MODE_RIGHT;
                else if (flags.front_clear && elapsed > confirm_ticks)
                    nxt = ogsc_pkg::MODE_FWD;
            end
            default: begin
                if (flags.ahead_blocked)
                    nxt = ogsc_pkg::MODE_BLOCKED;
            end
        endcase

        // Every change of state, a side flip included, restarts the dwell count.
        dwell = (nxt != mode) ? '0 : elapsed;
        mode  = nxt;

        res.mode_now = nxt;
        case (nxt)
            ogsc_pkg::MODE_FWD: begin
                res.motor_cmd = ogsc_pkg::CMD_FWD;
                res.duty      = forward_duty;
            end
            ogsc_pkg::MODE_LEFT: begin
                res.motor_cmd = ogsc_pkg::CMD_LEFT;
                res.duty      = side_duty;
            end
            ogsc_pkg::MODE_RIGHT: begin
                res.motor_cmd = ogsc_pkg::CMD_RIGHT;
                res.duty      = side_duty;
            end
            ogsc_pkg::MODE_CONFIRM: begin
                res.motor_cmd = prefer_left ? ogsc_pkg::CMD_LEFT : ogsc_pkg::CMD_RIGHT;
                res.duty      = side_duty;
            end
            default: begin
                res.motor_cmd = ogsc_pkg::CMD_STOP;
                res.duty      = '0;
            end
        endcase
        return res;
    endfunction

    // All channels are sampled at the rising edge, in the order in which the
    // block itself would see them.
    always @(posedge aclk) begin
        ogsc_pkg::result_t               got;
        ogsc_pkg::result_t               want;
        logic [ogsc_pkg::APB_DATA_W-1:0] reg_value;
        string                           reg_label;
        if (!aresetn) begin
            pause_ticks   = ogsc_pkg::PAUSE_TICKS_RST;
            confirm_ticks = ogsc_pkg::CONFIRM_TICKS_RST;
            forward_duty  = ogsc_pkg::FORWARD_DUTY_RST;
            side_duty     = ogsc_pkg::SIDE_DUTY_RST;
            mode          = ogsc_pkg::MODE_FWD;
            prefer_left   = 1'b1;
            dwell         = '0;
            pending_commands.delete();
        end else begin
            // Register writes and read-back.
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (paddr[3:2])
                        ogsc_pkg::REG_PAUSE_TICKS:
                            pause_ticks   = pwdata[ogsc_pkg::THRESH_W-1:0];
                        ogsc_pkg::REG_CONFIRM_TICKS:
                            confirm_ticks = pwdata[ogsc_pkg::THRESH_W-1:0];
                        ogsc_pkg::REG_FORWARD_DUTY:
                            forward_duty  = pwdata[ogsc_pkg::DUTY_W-1:0];
                        ogsc_pkg::REG_SIDE_DUTY:
                            side_duty     = pwdata[ogsc_pkg::DUTY_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (paddr[3:2])
                        ogsc_pkg::REG_PAUSE_TICKS: begin
                            reg_value = ogsc_pkg::APB_DATA_W'(pause_ticks);
                            reg_label = "pause_ticks";
                        end
                        ogsc_pkg::REG_CONFIRM_TICKS: begin
                            reg_value = ogsc_pkg::APB_DATA_W'(confirm_ticks);
                            reg_label = "confirm_ticks";
                        end
                        ogsc_pkg::REG_FORWARD_DUTY: begin
                            reg_value = ogsc_pkg::APB_DATA_W'(forward_duty);
                            reg_label = "forward_duty";
                        end
                        default: begin
                            reg_value = ogsc_pkg::APB_DATA_W'(side_duty);
                            reg_label = "side_duty";
                        end
                    endcase
                    if (prdata !== reg_value) begin
                        $error("%s: expected %0d, got %0d", reg_label, reg_value, prdata);
                        fail_count = fail_count + 1;
                    end
                end
            end

            // A result always belongs to an earlier request, so it is matched
            // before the request of this edge is predicted.
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(ogsc_pkg::result_t)-1:0];
                if (pending_commands.size() == 0) begin
                    $error("result with no request outstanding: mode_now %0d", got.mode_now);
                    fail_count = fail_count + 1;
                end else begin
                    want = pending_commands.pop_front();
                    if (got.mode_now !== want.mode_now) begin
                        $error("mode_now: expected %0d, got %0d", want.mode_now, got.mode_now);
                        fail_count = fail_count + 1;
                    end
                    if (got.motor_cmd !== want.motor_cmd) begin
                        $error("motor_cmd: expected %0d, got %0d",
                               want.motor_cmd, got.motor_cmd);
                        fail_count = fail_count + 1;
                    end
                    if (got.duty !== want.duty) begin
                        $error("duty: expected %0d, got %0d", want.duty, got.duty);
                        fail_count = fail_count + 1;
                    end
                end
            end

            // Each accepted request produces exactly one command.
            if (s_tvalid && s_tready)
                pending_commands.push_back(
                    advance_controller(ogsc_pkg::sensor_t'(s_tdata[3:0])));
        end
        pending_count = pending_commands.size();
    end

endmodule

// ===== test/tb_obstacle_gap_search_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_obstacle_gap_search_controller_unit;

    localparam int QUIET_LIMIT    = 1000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_REQUESTS = 232;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_tvalid;
    wire                             s_tready;
    // [0] ahead_blocked, [1] front_clear, [2] left_hit, [3] right_hit
    logic [ogsc_pkg::S_TDATA_W-1:0]  s_tdata;
    wire                             m_tvalid;
    logic                            m_tready;
    // [2:0] mode_now, [4:3] motor_cmd, [12:5] duty
    wire  [ogsc_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [ogsc_pkg::APB_ADDR_W-1:0] paddr;
    logic [ogsc_pkg::APB_DATA_W-1:0] pwdata;
    wire  [ogsc_pkg::APB_DATA_W-1:0] prdata;
    wire                             pready;

    int unsigned           fail_count;
    int unsigned           pending_count;
    int                    send_gap_pct;
    int                    stall_pct;
    int                    quiet_cycles;
    ogsc_pkg::sensor_t     directed_flags [0:19];

    obstacle_gap_search_controller_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ogsc_scoreboard u_scoreboard (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Clock with a 4 ns period.
    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // The receiver stalls at random, at the rate the current phase asks for.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Ends the run when nothing has moved on any channel for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One register access: the setup phase, then the access phase.
    task automatic apb_access(input logic [1:0] idx, input logic write,
                              input logic [ogsc_pkg::APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Writes all four registers and reads each one back.
    task automatic set_regs(input logic [ogsc_pkg::THRESH_W-1:0] pause_v,
                            input logic [ogsc_pkg::THRESH_W-1:0] confirm_v,
                            input logic [ogsc_pkg::DUTY_W-1:0] fwd_v,
                            input logic [ogsc_pkg::DUTY_W-1:0] side_v);
        apb_access(ogsc_pkg::REG_PAUSE_TICKS, 1'b1, ogsc_pkg::APB_DATA_W'(pause_v));
        apb_access(ogsc_pkg::REG_CONFIRM_TICKS, 1'b1, ogsc_pkg::APB_DATA_W'(confirm_v));
        apb_access(ogsc_pkg::REG_FORWARD_DUTY, 1'b1, ogsc_pkg::APB_DATA_W'(fwd_v));
        apb_access(ogsc_pkg::REG_SIDE_DUTY, 1'b1, ogsc_pkg::APB_DATA_W'(side_v));
        apb_access(ogsc_pkg::REG_PAUSE_TICKS, 1'b0, '0);
        apb_access(ogsc_pkg::REG_CONFIRM_TICKS, 1'b0, '0);
        apb_access(ogsc_pkg::REG_FORWARD_DUTY, 1'b0, '0);
        apb_access(ogsc_pkg::REG_SIDE_DUTY, 1'b0, '0);
    endtask

    // Holds off until every outstanding command has come back.
    task automatic wait_drained();
        while (pending_count != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    // Presents one request after an optional gap and waits for it to be taken.
    task automatic send_tick(input ogsc_pkg::sensor_t flags);
        while ($urandom_range(99) < send_gap_pct) @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {{(ogsc_pkg::S_TDATA_W-4){1'b0}}, flags};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Mostly plausible sensor readings, with some fully random noise.
    function automatic ogsc_pkg::sensor_t pick_flags();
        ogsc_pkg::sensor_t f;
        if ($urandom_range(99) < 20) begin
            f = ogsc_pkg::sensor_t'(4'($urandom_range(15)));
        end else begin
            f.ahead_blocked = ($urandom_range(99) < 20);
            f.front_clear   = ($urandom_range(99) < 45);
            f.left_hit      = ($urandom_range(99) < 15);
            f.right_hit     = ($urandom_range(99) < 15);
        end
        return f;
    endfunction

    initial begin
        int                            ph;
        int                            n;
        int                            k;
        int                            run;
        ogsc_pkg::sensor_t             pattern;
        logic [ogsc_pkg::THRESH_W-1:0] pause_v;
        logic [ogsc_pkg::THRESH_W-1:0] confirm_v;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        send_gap_pct = 0;
        stall_pct    = 0;
        quiet_cycles = 0;

        // Flags from right_hit down to ahead_blocked. Starting in front
        // blocked with a pause and a confirmation of one tick, this walks
        // every state, both side flips, the flag priorities in a search and
        // in confirm gap, a hold with neither front flag, and both sides of
        // each threshold.
        directed_flags = '{
            4'b1111, 4'b0000, 4'b0110, 4'b1010, 4'b0010,
            4'b0011, 4'b0100, 4'b0010, 4'b0001, 4'b0010,
            4'b0000, 4'b1100, 4'b0010, 4'b1110, 4'b0001,
            4'b0000, 4'b0000, 4'b0010, 4'b0010, 4'b0010
        };

        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset values: forward duty first, then stop on a blocked front.
        send_tick(ogsc_pkg::sensor_t'(4'b0000));
        send_tick(ogsc_pkg::sensor_t'(4'b0001));
        wait_drained();

        // Directed sequence with the duties at opposite extremes.
        set_regs(16'd1, 16'd1, 8'hFF, 8'h00);
        for (n = 0; n < 20; n++)
            send_tick(directed_flags[n]);
        wait_drained();

        // Confirmation thresholds at the top of the counter's range: a clear
        // front in confirm gap keeps the controller waiting.
        set_regs(16'd0, 16'hFFFE, 8'h5A, 8'hA5);
        send_tick(ogsc_pkg::sensor_t'(4'b0001));
        send_tick(ogsc_pkg::sensor_t'(4'b0000));
        send_tick(ogsc_pkg::sensor_t'(4'b0010));
        wait_drained();
        set_regs(16'd0, 16'hFFFF, 8'h5A, 8'hA5);
        send_tick(ogsc_pkg::sensor_t'(4'b0010));
        wait_drained();
        set_regs(16'd0, 16'hFFFE, 8'h5A, 8'hA5);
        send_tick(ogsc_pkg::sensor_t'(4'b0010));
        wait_drained();

        // Random phases, each with its own settings and idling pattern.
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 4)
                0: begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1: begin
                    send_gap_pct = 64;
                    stall_pct    = 0;
                end
                2: begin
                    send_gap_pct = 0;
                    stall_pct    = 64;
                end
                default: begin
                    send_gap_pct = 14;
                    stall_pct    = 14;
                end
            endcase
            pause_v   = (ph == 0) ? 16'd0 : (ph == RANDOM_PHASES - 1) ? 16'hFFFF
                      : ogsc_pkg::THRESH_W'($urandom_range(12));
            confirm_v = (ph == 0) ? 16'd0 : (ph == 3) ? 16'hFFFF
                      : ogsc_pkg::THRESH_W'($urandom_range(12));
            set_regs(pause_v, confirm_v, ogsc_pkg::DUTY_W'($urandom_range(255)),
                     ogsc_pkg::DUTY_W'($urandom_range(255)));

            // Runs of one reading model a sensor that stays put for a while.
            n = 0;
            while (n < PHASE_REQUESTS) begin
                pattern = pick_flags();
                run = $urandom_range(1, 14);
                for (k = 0; k < run && n < PHASE_REQUESTS; k++) begin
                    if (n == PHASE_REQUESTS / 2)
                        wait_drained();
                    send_tick(pattern);
                    n++;
                end
            end
            wait_drained();
        end

        // Let any stray result show up before the verdict.
        repeat (20) @(negedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ogsc_pkg.sv
hdl/ogsc_step.sv
hdl/obstacle_gap_search_controller_unit.sv
hdl/ogsc_checker.sv
test/ogsc_checker.sv
test/tb_obstacle_gap_search_controller_unit.sv
